@@ rtl/core/clsr_pkg.sv @@
// Shared constants and types for the current limit slew ramp.
package clsr_pkg;

  // Default widths of the current and delay fields
  localparam int unsigned DEFAULT_CURRENT_BITS = 12;
  localparam int unsigned DEFAULT_DELAY_BITS   = 10;

  // Input opcodes
  localparam int unsigned OPCODE_W = 2;
  localparam logic [OPCODE_W-1:0] OP_TICK   = 2'd0;
  localparam logic [OPCODE_W-1:0] OP_TARGET = 2'd1;
  localparam logic [OPCODE_W-1:0] OP_REINIT = 2'd2;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_STEP  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_DELAY = 1'b1;

  // Fixed levels in mA (truncated to the current width where used)
  localparam int unsigned DEFAULT_LEVEL  = 100;
  localparam int unsigned FALLBACK_LEVEL = 2000;

  // Depth of the command and result queues
  localparam int unsigned QUEUE_DEPTH = 2;

  // Commands passed from the front end to the back end
  typedef enum logic [1:0] {
    CMD_TICK,
    CMD_TARGET,
    CMD_REINIT
  } cmd_e;

endpackage

@@ rtl/core/clsr_fifo.sv @@
// Small flop-based FIFO used for the command and result queues.
module clsr_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             wr_en_i,
  input  logic [WIDTH-1:0] wr_data_i,
  input  logic             rd_en_i,
  output logic [WIDTH-1:0] rd_data_o,
  output logic             full_o,
  output logic             empty_o
);

  localparam int unsigned PtrW = $clog2(DEPTH);
  localparam int unsigned CntW = $clog2(DEPTH + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(DEPTH - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(DEPTH);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PtrW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]  cnt_q;
  logic             do_wr, do_rd;

  assign full_o    = (cnt_q == FullCnt);
  assign empty_o   = (cnt_q == '0);
  assign do_wr     = wr_en_i && !full_o;
  assign do_rd     = rd_en_i && !empty_o;
  assign rd_data_o = mem_q[rd_ptr_q];

  // Pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr_q <= (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_rd) begin
        rd_ptr_q <= (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_wr && !do_rd) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_rd && !do_wr) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  // Storage, no reset needed
  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wr_ptr_q] <= wr_data_i;
    end
  end

endmodule

@@ rtl/core/clsr_front.sv @@
// Front end: accepts input requests and classifies them into commands.
module clsr_front #(
  parameter int unsigned CURRENT_BITS = clsr_pkg::DEFAULT_CURRENT_BITS
) (
  input  logic                          push_i,
  input  logic [clsr_pkg::OPCODE_W-1:0] opcode_i,
  input  logic [CURRENT_BITS-1:0]       target_ma_i,
  input  logic                          ramp_off_i,
  input  logic                          cmd_full_i,
  output logic                          cmd_push_o,
  output clsr_pkg::cmd_e                cmd_op_o,
  output logic [CURRENT_BITS-1:0]       cmd_target_o
);

  logic keep;

  // Decode; rejected targets and unknown opcodes are dropped here
  always_comb begin
    keep     = 1'b0;
    cmd_op_o = clsr_pkg::CMD_TICK;
    unique case (opcode_i)
      clsr_pkg::OP_TICK: begin
        keep     = 1'b1;
        cmd_op_o = clsr_pkg::CMD_TICK;
      end
      clsr_pkg::OP_TARGET: begin
        keep     = (target_ma_i != '0) && !ramp_off_i;
        cmd_op_o = clsr_pkg::CMD_TARGET;
      end
      clsr_pkg::OP_REINIT: begin
        keep     = 1'b1;
        cmd_op_o = clsr_pkg::CMD_REINIT;
      end
      default: begin
        keep     = 1'b0;
        cmd_op_o = clsr_pkg::CMD_TICK;
      end
    endcase
  end

  assign cmd_push_o   = push_i && !cmd_full_i && keep;
  assign cmd_target_o = target_ma_i;

endmodule

@@ rtl/core/clsr_back.sv @@
// Back end: ramp state, timing and configuration; produces limit writes.
module clsr_back #(
  parameter int unsigned CURRENT_BITS = clsr_pkg::DEFAULT_CURRENT_BITS,
  parameter int unsigned DELAY_BITS   = clsr_pkg::DEFAULT_DELAY_BITS,
  parameter int unsigned CFG_W        = CURRENT_BITS
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // configuration
  input  logic                           cfg_we_i,
  input  logic [clsr_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]               cfg_data_i,
  output logic                           ramp_off_o,
  // command queue side
  input  logic                           cmd_valid_i,
  input  clsr_pkg::cmd_e                 cmd_op_i,
  input  logic [CURRENT_BITS-1:0]        cmd_target_i,
  output logic                           cmd_pop_o,
  // result queue side
  input  logic                           res_full_i,
  output logic                           res_push_o,
  output logic [CURRENT_BITS-1:0]        res_limit_o,
  output logic                           res_final_o
);

  localparam int unsigned WaitW = DELAY_BITS + 1;
  localparam logic [CURRENT_BITS-1:0] DefLevel  = CURRENT_BITS'(clsr_pkg::DEFAULT_LEVEL);
  localparam logic [CURRENT_BITS-1:0] FallLevel = CURRENT_BITS'(clsr_pkg::FALLBACK_LEVEL);

  logic [CURRENT_BITS-1:0] step_q;
  logic [DELAY_BITS-1:0]   delay_q;

  logic [CURRENT_BITS-1:0] present_q, present_d;
  logic [CURRENT_BITS-1:0] ramp_q, ramp_d;
  logic [CURRENT_BITS-1:0] goal_q, goal_d;
  logic                    up_q, up_d;
  logic [WaitW-1:0]        wait_q, wait_d;
  logic                    ramping_q, ramping_d;
  logic                    abort_q, abort_d;

  logic                    go, do_start, do_finish, do_step, reached;
  logic [WaitW-1:0]        wait_dec;
  logic [CURRENT_BITS-1:0] goal_eff, adv_v, adv_out;
  logic                    adv_up;
  logic [CURRENT_BITS:0]   adv_sum;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q  <= '0;
      delay_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        clsr_pkg::REG_STEP:  step_q  <= cfg_data_i[CURRENT_BITS-1:0];
        clsr_pkg::REG_DELAY: delay_q <= cfg_data_i[DELAY_BITS-1:0];
      endcase
    end
  end

  assign ramp_off_o = (step_q == '0) || (delay_q == '0);
  assign go         = cmd_valid_i && !res_full_i;
  assign cmd_pop_o  = go;
  assign wait_dec   = (wait_q != '0) ? wait_q - 1'b1 : '0;
  assign goal_eff   = (cmd_op_i == clsr_pkg::CMD_TARGET) ? cmd_target_i : goal_q;
  assign reached    = up_q ? (ramp_q >= goal_q) : (ramp_q <= goal_q);

  // Shared saturating step unit: start of ramp uses the present level
  assign adv_v   = do_start ? present_q : ramp_q;
  assign adv_up  = do_start ? (goal_eff > present_q) : up_q;
  assign adv_sum = {1'b0, adv_v} + {1'b0, step_q};
  always_comb begin
    if (adv_up) begin
      adv_out = adv_sum[CURRENT_BITS] ? '1 : adv_sum[CURRENT_BITS-1:0];
    end else begin
      adv_out = (adv_v < step_q) ? '0 : adv_v - step_q;
    end
  end

  // Command execution
  always_comb begin
    present_d   = present_q;
    ramp_d      = ramp_q;
    goal_d      = goal_q;
    up_d        = up_q;
    wait_d      = wait_q;
    ramping_d   = ramping_q;
    abort_d     = abort_q;
    res_push_o  = 1'b0;
    res_limit_o = present_q;
    res_final_o = 1'b0;
    do_start    = 1'b0;
    do_finish   = 1'b0;
    do_step     = 1'b0;

    if (go) begin
      unique case (cmd_op_i)
        clsr_pkg::CMD_TICK: begin
          if (ramping_q || abort_q) begin
            wait_d = wait_dec;
            if (wait_dec == '0) begin
              if (abort_q) begin
                do_start = 1'b1;
              end else if (ramp_off_o || reached) begin
                do_finish = 1'b1;
              end else begin
                do_step = 1'b1;
              end
            end
          end
        end
        clsr_pkg::CMD_TARGET: begin
          goal_d = cmd_target_i;
          if (!abort_q) begin
            if (ramping_q) begin
              // abort: wait twice the delay, no final write
              ramping_d = 1'b0;
              abort_d   = 1'b1;
              wait_d    = {delay_q, 1'b0};
            end else begin
              do_start = 1'b1;
            end
          end
        end
        clsr_pkg::CMD_REINIT: begin
          present_d = DefLevel;
          ramping_d = 1'b0;
          abort_d   = 1'b0;
          wait_d    = '0;
          if (ramp_off_o) begin
            res_push_o  = 1'b1;
            res_limit_o = FallLevel;
            res_final_o = 1'b1;
          end
        end
        default: ;
      endcase
    end

    // Ramp start: settle at once when disabled or already there
    if (do_start) begin
      abort_d = 1'b0;
      if (ramp_off_o || (goal_eff == present_q)) begin
        do_finish = 1'b1;
      end else begin
        up_d        = goal_eff > present_q;
        ramp_d      = adv_out;
        ramping_d   = 1'b1;
        wait_d      = {1'b0, delay_q};
        res_push_o  = 1'b1;
        res_limit_o = present_q;
        res_final_o = 1'b0;
      end
    end

    // Intermediate step
    if (do_step) begin
      present_d   = ramp_q;
      ramp_d      = adv_out;
      wait_d      = {1'b0, delay_q};
      res_push_o  = 1'b1;
      res_limit_o = ramp_q;
      res_final_o = 1'b0;
    end

    // Final write of the goal
    if (do_finish) begin
      present_d   = goal_eff;
      ramping_d   = 1'b0;
      abort_d     = 1'b0;
      wait_d      = '0;
      res_push_o  = 1'b1;
      res_limit_o = goal_eff;
      res_final_o = 1'b1;
    end
  end

  // Ramp state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      present_q <= DefLevel;
      ramp_q    <= '0;
      goal_q    <= '0;
      up_q      <= 1'b0;
      wait_q    <= '0;
      ramping_q <= 1'b0;
      abort_q   <= 1'b0;
    end else begin
      present_q <= present_d;
      ramp_q    <= ramp_d;
      goal_q    <= goal_d;
      up_q      <= up_d;
      wait_q    <= wait_d;
      ramping_q <= ramping_d;
      abort_q   <= abort_d;
    end
  end

endmodule

@@ rtl/core/current_limit_slew_ramp.sv @@
// Top level: front end, command queue, ramp back end and result queue.
// A request is registered in the command queue, then its result in the result queue.
// Throughput: one request per cycle; full rises only when the result side stalls
// and both the two-entry command queue and two-entry result queue fill up.
// Reset clears both queues, the config registers to zero, and the level to 100 mA.
module current_limit_slew_ramp #(
  parameter int unsigned CURRENT_BITS = clsr_pkg::DEFAULT_CURRENT_BITS,
  parameter int unsigned DELAY_BITS   = clsr_pkg::DEFAULT_DELAY_BITS,
  parameter int unsigned CFG_W = (CURRENT_BITS > DELAY_BITS) ? CURRENT_BITS : DELAY_BITS
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // configuration
  input  logic                           cfg_we_i,
  input  logic [clsr_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]               cfg_data_i,
  // requests
  input  logic                           push,
  output logic                           full,
  input  logic [clsr_pkg::OPCODE_W-1:0]  opcode_i,
  input  logic [CURRENT_BITS-1:0]        target_ma_i,
  // results
  output logic                           empty,
  input  logic                           pop,
  output logic [CURRENT_BITS-1:0]        limit_ma_o,
  output logic                           is_final_o
);

  localparam int unsigned CmdW = $bits(clsr_pkg::cmd_e) + CURRENT_BITS;
  localparam int unsigned ResW = CURRENT_BITS + 1;

  logic                    ramp_off;
  logic                    cmd_push, cmd_full, cmd_empty, cmd_pop;
  clsr_pkg::cmd_e          fe_op, be_op;
  logic [CURRENT_BITS-1:0] fe_target, be_target;
  logic [CmdW-1:0]         cmd_rd;
  logic                    res_push, res_full, res_final;
  logic [CURRENT_BITS-1:0] res_limit;
  logic [ResW-1:0]         res_rd;

  assign full = cmd_full;

  // Classify incoming requests
  clsr_front #(
    .CURRENT_BITS(CURRENT_BITS)
  ) u_front (
    .push_i      (push),
    .opcode_i    (opcode_i),
    .target_ma_i (target_ma_i),
    .ramp_off_i  (ramp_off),
    .cmd_full_i  (cmd_full),
    .cmd_push_o  (cmd_push),
    .cmd_op_o    (fe_op),
    .cmd_target_o(fe_target)
  );

  // Command queue between front and back
  clsr_fifo #(
    .WIDTH(CmdW),
    .DEPTH(clsr_pkg::QUEUE_DEPTH)
  ) u_cmd_q (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .wr_en_i  (cmd_push),
    .wr_data_i({fe_op, fe_target}),
    .rd_en_i  (cmd_pop),
    .rd_data_o(cmd_rd),
    .full_o   (cmd_full),
    .empty_o  (cmd_empty)
  );

  assign be_op     = clsr_pkg::cmd_e'(cmd_rd[CmdW-1:CURRENT_BITS]);
  assign be_target = cmd_rd[CURRENT_BITS-1:0];

  // Ramp execution
  clsr_back #(
    .CURRENT_BITS(CURRENT_BITS),
    .DELAY_BITS  (DELAY_BITS),
    .CFG_W       (CFG_W)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .ramp_off_o  (ramp_off),
    .cmd_valid_i (!cmd_empty),
    .cmd_op_i    (be_op),
    .cmd_target_i(be_target),
    .cmd_pop_o   (cmd_pop),
    .res_full_i  (res_full),
    .res_push_o  (res_push),
    .res_limit_o (res_limit),
    .res_final_o (res_final)
  );

  // Result queue
  clsr_fifo #(
    .WIDTH(ResW),
    .DEPTH(clsr_pkg::QUEUE_DEPTH)
  ) u_res_q (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .wr_en_i  (res_push),
    .wr_data_i({res_final, res_limit}),
    .rd_en_i  (pop),
    .rd_data_o(res_rd),
    .full_o   (res_full),
    .empty_o  (empty)
  );

  assign is_final_o = res_rd[ResW-1];
  assign limit_ma_o = res_rd[CURRENT_BITS-1:0];

  // Back end never writes a result into a full queue
  a_res_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_push |-> !res_full)
    else $error("result written into full queue");

  // Back end only consumes commands that exist
  a_cmd_pop_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_pop |-> !cmd_empty)
    else $error("command popped from empty queue");

  // A result appears only after the back end wrote one
  a_res_from_back: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(empty) |-> $past(res_push))
    else $error("result appeared without a write");

  // Commands are queued only from accepted requests
  a_cmd_from_push: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_push |-> (push && !full))
    else $error("command queued without an accepted request");

endmodule

@@ verif/current_limit_slew_ramp_test.sv @@
// Self-checking testbench for the current limit slew ramp: directed and random requests.
`timescale 1ns / 1ps

module current_limit_slew_ramp_test;

  localparam int unsigned CB    = clsr_pkg::DEFAULT_CURRENT_BITS;
  localparam int unsigned DB    = clsr_pkg::DEFAULT_DELAY_BITS;
  localparam int unsigned CFG_W = (CB > DB) ? CB : DB;

  // opcode 3 has no name in the package; the block ignores it
  localparam logic [clsr_pkg::OPCODE_W-1:0] OP_UNUSED = 2'd3;

  localparam logic [CB-1:0] LEVEL_MAX = {CB{1'b1}};

  localparam int unsigned RANDOM_PHASES = 9;
  localparam int unsigned PHASE_ITEMS   = 100;
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned DRAIN_LIMIT   = 20000;
  localparam int unsigned HOLD_CYCLES   = 400;

  // Predicts the limit writes and checks them in order
  class ramp_scoreboard;
    typedef struct packed {
      logic [CB-1:0] limit;
      logic          fin;
    } limit_write_t;

    limit_write_t  due_q[$];
    int unsigned   errors;

    logic [CB-1:0] step;
    logic [DB-1:0] delay;
    logic [CB-1:0] level;
    logic [CB-1:0] next_level;
    logic [CB-1:0] goal;
    logic          rising;
    logic [DB:0]   wait_cnt;
    logic          ramping;
    logic          aborting;

    function new();
      errors     = 0;
      step       = '0;
      delay      = '0;
      level      = CB'(clsr_pkg::DEFAULT_LEVEL);
      next_level = '0;
      goal       = '0;
      rising     = 1'b0;
      wait_cnt   = '0;
      ramping    = 1'b0;
      aborting   = 1'b0;
    endfunction

    function void set_reg(logic [clsr_pkg::CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
      if (idx == clsr_pkg::REG_STEP) step = data[CB-1:0];
      else delay = data[DB-1:0];
    endfunction

    function logic disabled();
      return (step == '0) || (delay == '0);
    endfunction

    // one step toward the goal, saturating at both ends
    function logic [CB-1:0] stepped(logic [CB-1:0] v);
      logic [CB:0] sum;
      if (rising) begin
        sum = {1'b0, v} + {1'b0, step};
        return (sum > {1'b0, LEVEL_MAX}) ? LEVEL_MAX : sum[CB-1:0];
      end
      return (v < step) ? '0 : v - step;
    endfunction

    function void emit(logic [CB-1:0] lim, logic fin);
      limit_write_t w;
      w.limit = lim;
      w.fin   = fin;
      due_q.push_back(w);
    endfunction

    function void finish_ramp();
      level    = goal;
      ramping  = 1'b0;
      aborting = 1'b0;
      wait_cnt = '0;
      emit(goal, 1'b1);
    endfunction

    function void start_ramp();
      aborting = 1'b0;
      if (disabled() || goal == level) begin
        finish_ramp();
        return;
      end
      rising     = goal > level;
      next_level = stepped(level);
      ramping    = 1'b1;
      wait_cnt   = {1'b0, delay};
      emit(level, 1'b0);
    endfunction

    function void tick();
      logic reached;
      if (!ramping && !aborting) return;
      if (wait_cnt != '0) wait_cnt = wait_cnt - 1'b1;
      if (wait_cnt != '0) return;
      if (aborting) begin
        start_ramp();
        return;
      end
      if (disabled()) begin
        finish_ramp();
        return;
      end
      reached = rising ? (next_level >= goal) : (next_level <= goal);
      if (reached) begin
        finish_ramp();
        return;
      end
      level      = next_level;
      next_level = stepped(next_level);
      wait_cnt   = {1'b0, delay};
      emit(level, 1'b0);
    endfunction

    function void retarget(logic [CB-1:0] tgt);
      if (tgt == '0 || disabled()) return;
      goal = tgt;
      if (aborting) return;
      // new goal mid-ramp: drop the ramp and wait twice the delay
      if (ramping) begin
        ramping  = 1'b0;
        aborting = 1'b1;
        wait_cnt = {delay, 1'b0};
        return;
      end
      start_ramp();
    endfunction

    function void reinit();
      level    = CB'(clsr_pkg::DEFAULT_LEVEL);
      ramping  = 1'b0;
      aborting = 1'b0;
      wait_cnt = '0;
      if (disabled()) emit(CB'(clsr_pkg::FALLBACK_LEVEL), 1'b1);
    endfunction

    function void note_request(logic [clsr_pkg::OPCODE_W-1:0] op, logic [CB-1:0] tgt);
      case (op)
        clsr_pkg::OP_TICK:   tick();
        clsr_pkg::OP_TARGET: retarget(tgt);
        clsr_pkg::OP_REINIT: reinit();
        default: ;
      endcase
    endfunction

    task report(string msg);
      $display("[%0t] mismatch: %s", $realtime, msg);
      errors++;
    endtask

    task check_result(logic [CB-1:0] lim, logic fin);
      limit_write_t w;
      if (due_q.size() == 0) begin
        report($sformatf("unexpected write limit=%0d final=%0b", lim, fin));
        return;
      end
      w = due_q.pop_front();
      if (lim !== w.limit)
        report($sformatf("limit_ma %0d, expected %0d", lim, w.limit));
      if (fin !== w.fin)
        report($sformatf("is_final %0b, expected %0b (limit %0d)", fin, w.fin, w.limit));
    endtask
  endclass

  logic                           clk_i;
  logic                           rst_ni;
  logic                           cfg_we_i;
  logic [clsr_pkg::CFG_IDX_W-1:0] cfg_idx_i;
  logic [CFG_W-1:0]               cfg_data_i;
  logic                           push;
  logic                           full;
  logic [clsr_pkg::OPCODE_W-1:0]  opcode_i;
  logic [CB-1:0]                  target_ma_i;
  logic                           empty;
  logic                           pop;
  logic [CB-1:0]                  limit_ma_o;
  logic                           is_final_o;

  ramp_scoreboard sb;
  int unsigned    idle_mode;
  bit             hold_off_req;

  current_limit_slew_ramp u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .push        (push),
    .full        (full),
    .opcode_i    (opcode_i),
    .target_ma_i (target_ma_i),
    .empty       (empty),
    .pop         (pop),
    .limit_ma_o  (limit_ma_o),
    .is_final_o  (is_final_o)
  );

  // 2 ns clock
  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // idle odds per mode: receiver-heavy, sender-heavy, none
  function automatic bit sender_idles();
    case (idle_mode)
      0: return $urandom_range(99) < 25;
      1: return $urandom_range(99) < 53;
      default: return 1'b0;
    endcase
  endfunction

  function automatic bit receiver_idles();
    case (idle_mode)
      0: return $urandom_range(99) < 53;
      1: return $urandom_range(99) < 25;
      default: return 1'b0;
    endcase
  endfunction

  // Offer one request and wait until it is taken
  task automatic send_item(logic [clsr_pkg::OPCODE_W-1:0] op, logic [CB-1:0] tgt);
    @(negedge clk_i);
    while (sender_idles()) begin
      push <= 1'b0;
      @(negedge clk_i);
    end
    push        <= 1'b1;
    opcode_i    <= op;
    target_ma_i <= tgt;
    do @(posedge clk_i); while (full);
    sb.note_request(op, tgt);
  endtask

  task automatic send_ticks(int unsigned n);
    repeat (n) send_item(clsr_pkg::OP_TICK, CB'($urandom));
  endtask

  // Stop offering, let every expected write arrive, then let the pipe empty
  task automatic drain_requests();
    int unsigned guard;
    @(negedge clk_i);
    push  <= 1'b0;
    guard = 0;
    while (sb.due_q.size() != 0 && guard < DRAIN_LIMIT) begin
      @(posedge clk_i);
      guard++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [clsr_pkg::CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    sb.set_reg(idx, data);
    @(negedge clk_i);
    cfg_we_i   <= 1'b0;
  endtask

  // Result side: random pop, with one long hold-off on request
  initial begin : receiver
    int unsigned hold_left;
    pop       = 1'b0;
    hold_left = 0;
    forever begin
      @(negedge clk_i);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        hold_left    = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
        hold_left--;
        pop <= 1'b0;
      end else begin
        pop <= !receiver_idles();
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && pop && !empty) sb.check_result(limit_ma_o, is_final_o);
  end

  // Run limit
  initial begin
    #400000;
    $display("** current_limit_slew_ramp: FAILED **");
    $finish;
  end

  initial begin : stimulus
    int unsigned    ph;
    int unsigned    n;
    int unsigned    pick;
    logic [CB-1:0]  step_val;
    logic [CFG_W-1:0] delay_val;
    logic [CB-1:0]  tgt;

    sb           = new();
    idle_mode    = 0;
    hold_off_req = 1'b0;
    rst_ni       = 1'b0;
    cfg_we_i     = 1'b0;
    cfg_idx_i    = clsr_pkg::REG_STEP;
    cfg_data_i   = '0;
    push         = 1'b0;
    opcode_i     = clsr_pkg::OP_TICK;
    target_ma_i  = '0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // ramping disabled after reset: rejected target, fallback reinit, idle tick, unknown op
    send_item(clsr_pkg::OP_TARGET, LEVEL_MAX);
    send_item(clsr_pkg::OP_REINIT, CB'($urandom));
    send_item(clsr_pkg::OP_TICK, '0);
    send_item(OP_UNUSED, 12'hABC);
    drain_requests();

    // largest step, shortest delay: equal target, saturating up and down, zero target
    write_reg(clsr_pkg::REG_STEP, CFG_W'(LEVEL_MAX));
    write_reg(clsr_pkg::REG_DELAY, CFG_W'(1));
    send_item(clsr_pkg::OP_TARGET, CB'(clsr_pkg::DEFAULT_LEVEL));
    send_item(clsr_pkg::OP_TARGET, LEVEL_MAX);
    send_ticks(1);
    send_item(clsr_pkg::OP_TARGET, CB'(1));
    send_ticks(1);
    send_item(clsr_pkg::OP_TARGET, '0);
    drain_requests();

    // abort mid-ramp, retarget during the abort wait, then disable mid-ramp
    write_reg(clsr_pkg::REG_STEP, CFG_W'(1000));
    write_reg(clsr_pkg::REG_DELAY, CFG_W'(2));
    send_item(clsr_pkg::OP_TARGET, CB'(3000));
    send_ticks(2);
    send_item(clsr_pkg::OP_TARGET, CB'(500));
    send_item(clsr_pkg::OP_TARGET, CB'(2500));
    send_ticks(4);
    drain_requests();
    write_reg(clsr_pkg::REG_STEP, '0);
    send_ticks(2);
    send_item(clsr_pkg::OP_REINIT, '0);
    drain_requests();

    // longest delay, written with the upper data bits set
    write_reg(clsr_pkg::REG_STEP, CFG_W'(12));
    write_reg(clsr_pkg::REG_DELAY, {CFG_W{1'b1}});
    send_item(clsr_pkg::OP_TARGET, CB'(50));
    send_ticks(1);
    send_item(clsr_pkg::OP_REINIT, '0);
    drain_requests();

    // random phases
    for (ph = 0; ph < RANDOM_PHASES; ph++) begin
      idle_mode = ph / 3;
      if (ph == 6) begin
        // small step, shortest delay so ticks keep writing, then a long receiver stall to fill the queues
        step_val  = CB'(50);
        delay_val = CFG_W'(1);
      end else begin
        pick = $urandom_range(99);
        if (pick < 10) step_val = '0;
        else if (pick < 20) step_val = LEVEL_MAX;
        else if (pick < 35) step_val = CB'($urandom_range(63, 1));
        else step_val = CB'($urandom_range(1500, 64));
        pick = $urandom_range(99);
        if (pick < 8) delay_val = '0;
        else if (pick < 15) delay_val = {2'($urandom), 10'h3FF};
        else delay_val = CFG_W'($urandom_range(6, 1));
      end
      write_reg(clsr_pkg::REG_STEP, CFG_W'(step_val));
      write_reg(clsr_pkg::REG_DELAY, delay_val);
      if (ph == 6) hold_off_req = 1'b1;

      for (n = 0; n < PHASE_ITEMS; n++) begin
        pick = $urandom_range(99);
        if (pick < 68) begin
          send_item(clsr_pkg::OP_TICK, CB'($urandom));
        end else if (pick < 90) begin
          pick = $urandom_range(99);
          if (pick < 8) tgt = '0;
          else if (pick < 20) tgt = sb.level;
          else if (pick < 28) tgt = LEVEL_MAX;
          else tgt = CB'($urandom);
          send_item(clsr_pkg::OP_TARGET, tgt);
        end else if (pick < 97) begin
          send_item(clsr_pkg::OP_REINIT, CB'($urandom));
        end else begin
          send_item(OP_UNUSED, CB'($urandom));
        end
      end
      // long delays would stall later phases; clear any pending ramp
      if (sb.delay > 6) send_item(clsr_pkg::OP_REINIT, '0);
      drain_requests();
    end

    repeat (20) @(posedge clk_i);
    if (sb.due_q.size() != 0)
      sb.report($sformatf("%0d expected writes never arrived", sb.due_q.size()));
    if (sb.errors == 0) begin
      $display("** current_limit_slew_ramp: PASSED **");
    end else begin
      $display("** current_limit_slew_ramp: FAILED **");
    end
    $finish;
  end

endmodule
